// ----- design/hgagg_pkg.sv -----
// Shared types, constants and helper functions of the group-by aggregation core.
package hgagg_pkg;

	localparam int SLOTS = 1024;
	localparam int IDX_W = $clog2(SLOTS);
	localparam int POS_W = IDX_W + 1;

	localparam logic [63:0] MIX_ADD = 64'h9e3779b97f4a7c15;
	localparam logic [63:0] MIX_MUL1 = 64'hbf58476d1ce4e5b9;
	localparam logic [63:0] MIX_MUL2 = 64'h94d049bb133111eb;
	localparam logic [63:0] WIDE_MUL = 64'h3c79ac492ba7b653;
	localparam logic [63:0] WIDE_ADD = 64'h1c69b3f74ac4ae35;

	localparam logic [1:0] CMD_UPDATE = 2'd0;
	localparam logic [1:0] CMD_READ = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;
	localparam logic [1:0] CMD_SPARE = 2'd3;

	localparam logic [2:0] ST_UPDATED = 3'd0;
	localparam logic [2:0] ST_NEW = 3'd1;
	localparam logic [2:0] ST_DROPPED = 3'd2;
	localparam logic [2:0] ST_GROUP = 3'd3;
	localparam logic [2:0] ST_NO_MORE = 3'd4;
	localparam logic [2:0] ST_CLEARED = 3'd5;

	localparam logic REG_KEY_LEN = 1'b0;
	localparam logic REG_MAX_GROUPS = 1'b1;

	localparam logic [3:0] KEY_LEN_RST = 4'd8;
	localparam logic [10:0] MAX_GROUPS_RST = 11'd716;

	typedef struct packed {
		logic [1:0] cmd;
		logic [63:0] key;
		logic signed [63:0] value;
	} request_t;

	typedef struct packed {
		logic [2:0] status;
		logic [63:0] group_key;
		logic [47:0] row_count;
		logic [63:0] sum_low;
		logic signed [63:0] sum_high;
		logic signed [63:0] min_value;
		logic signed [63:0] max_value;
		logic last_group;
	} result_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic [63:0] key;
		logic signed [63:0] value;
		logic [63:0] mask;
		logic [IDX_W-1:0] idx;
	} work_t;

	typedef struct packed {
		logic valid;
		logic [63:0] key;
		logic [47:0] count;
		logic [63:0] sum_lo;
		logic [63:0] sum_hi;
		logic [63:0] min;
		logic [63:0] max;
	} entry_t;

	function automatic logic [3:0] eff_bytes(input logic [3:0] kb);
		logic [3:0] n;
		n = kb;
		if (kb == 4'd0) n = 4'd1;
		else if (kb > 4'd8) n = 4'd8;
		return n;
	endfunction

	function automatic logic [63:0] key_mask(input logic [3:0] kb);
		logic [63:0] m;
		logic [3:0] n;
		n = eff_bytes(kb);
		for (int b = 0; b < 8; b++) begin
			m[8*b +: 8] = (4'(b) < n) ? 8'hff : 8'h00;
		end
		return m;
	endfunction

endpackage

// ----- design/hash_group_aggregate_core.sv -----
// Top level of the group-by aggregation core: configuration registers and the three units.
//
// A command transaction (cmd, key, value on request) is taken on a clock edge with start
// high and busy low. Each command yields exactly one result, shown on result for one
// cycle with done high; the receiver cannot stall it.
// Update: the front end hashes the masked key on one shared 32x32 multiplier, three
// partial products per 64-bit product; eight-byte keys add a rotate-and-multiply step.
// The back end then probes the table one slot a cycle; an update of an existing group
// then passes through the states B_UPD1 and B_UPD2. A two-entry queue between them
// lets the next command be hashed while the back end works.
// Read-next scans slots one a cycle from the scan position to the hit and on to the next
// valid slot. Clear sweeps all 1024 slots. The spare command answers with status no-more.
// After reset the table is swept, all 1024 slots, during which busy is high;
// configuration writes (cfg_we, cfg_index, cfg_data) are taken in any cycle.
module hash_group_aggregate_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  hgagg_pkg::request_t request,
	output logic                done,
	output hgagg_pkg::result_t  result,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [10:0]         cfg_data
);
	import hgagg_pkg::*;

	logic [3:0] key_len_q;
	logic [10:0] max_groups_q;
	logic front_busy, init_busy, push, full, pop, empty;
	work_t push_item, head;

	assign busy = front_busy | init_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_len_q <= KEY_LEN_RST;
			max_groups_q <= MAX_GROUPS_RST;
		end else if (cfg_we) begin
			if (cfg_index == REG_KEY_LEN) key_len_q <= cfg_data[3:0];
			else max_groups_q <= cfg_data;
		end
	end

	hgagg_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start & ~init_busy),
		.busy      (front_busy),
		.request   (request),
		.key_len   (key_len_q),
		.push      (push),
		.push_item (push_item),
		.full      (full)
	);

	hgagg_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (full),
		.pop       (pop),
		.head      (head),
		.empty     (empty)
	);

	hgagg_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.max_groups (max_groups_q),
		.empty      (empty),
		.head       (head),
		.pop        (pop),
		.init_busy  (init_busy),
		.done       (done),
		.result     (result)
	);

endmodule

// ----- design/hgagg_queue.sv -----
// Two-entry work queue between the hashing front end and the table back end.
module hgagg_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  hgagg_pkg::work_t  push_item,
	output logic              full,
	input  logic              pop,
	output hgagg_pkg::work_t  head,
	output logic              empty
);
	import hgagg_pkg::*;

	work_t slot_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign head = slot_q[rp_q];

	always_ff @(posedge clk) begin
		if (push && !full) slot_q[wp_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push && !full) wp_q <= ~wp_q;
			if (pop && !empty) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
		end
	end

endmodule

// ----- design/hgagg_front.sv -----
// Front end: takes commands, masks keys and computes the slot hash on a shared multiplier.
module hgagg_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  hgagg_pkg::request_t request,
	input  logic [3:0]          key_len,
	output logic                push,
	output hgagg_pkg::work_t    push_item,
	input  logic                full
);
	import hgagg_pkg::*;

	localparam logic [2:0] F_IDLE = 3'd0;
	localparam logic [2:0] F_LOAD = 3'd1;
	localparam logic [2:0] F_MUL = 3'd2;
	localparam logic [2:0] F_POST = 3'd3;
	localparam logic [2:0] F_PUSH = 3'd4;

	localparam logic [1:0] OP_N = 2'd0;
	localparam logic [1:0] OP_K = 2'd1;
	localparam logic [1:0] OP_ROT = 2'd2;
	localparam logic [1:0] OP_FINAL = 2'd3;

	logic [2:0] fst_q;
	logic [1:0] op_q, mph_q;
	logic half_q, wide_q;
	logic [63:0] opa_q, acc_q, x_q, hn_q, key_q, mask_q;
	logic signed [63:0] val_q;
	logic [1:0] cmd_q;
	logic [IDX_W-1:0] idx_q;

	logic [63:0] opb, prod, mixed, y;
	logic [31:0] ma, mb;

	assign busy = fst_q != F_IDLE;
	assign push = (fst_q == F_PUSH) && !full;
	assign push_item = '{cmd: cmd_q, key: key_q, value: val_q, mask: mask_q, idx: idx_q};

	assign opb = (op_q == OP_ROT) ? WIDE_MUL : (half_q ? MIX_MUL2 : MIX_MUL1);
	assign y = x_q + MIX_ADD;
	assign mixed = acc_q ^ (acc_q >> 31);
	assign prod = {32'b0, ma} * {32'b0, mb};

	always_comb begin
		case (mph_q)
			2'd0: begin ma = opa_q[31:0]; mb = opb[31:0]; end
			2'd1: begin ma = opa_q[31:0]; mb = opb[63:32]; end
			default: begin ma = opa_q[63:32]; mb = opb[31:0]; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fst_q <= F_IDLE;
			op_q <= OP_N;
			mph_q <= 2'd0;
			half_q <= 1'b0;
		end else begin
			case (fst_q)
				F_IDLE: if (start) begin
					op_q <= OP_N;
					fst_q <= (request.cmd == CMD_UPDATE) ? F_LOAD : F_PUSH;
				end
				F_LOAD: begin
					half_q <= 1'b0;
					mph_q <= 2'd0;
					fst_q <= F_MUL;
				end
				F_MUL: begin
					mph_q <= mph_q + 2'd1;
					if (mph_q == 2'd2) fst_q <= F_POST;
				end
				F_POST: begin
					mph_q <= 2'd0;
					if (op_q == OP_ROT) begin
						op_q <= OP_FINAL;
						fst_q <= F_LOAD;
					end else if (!half_q) begin
						half_q <= 1'b1;
						fst_q <= F_MUL;
					end else begin
						case (op_q)
							OP_N: begin op_q <= OP_K; fst_q <= F_LOAD; end
							OP_K: begin
								op_q <= wide_q ? OP_ROT : OP_FINAL;
								fst_q <= F_LOAD;
							end
							default: fst_q <= F_PUSH;
						endcase
					end
				end
				F_PUSH: if (!full) fst_q <= F_IDLE;
				default: fst_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (fst_q)
			F_IDLE: if (start) begin
				cmd_q <= request.cmd;
				mask_q <= key_mask(key_len);
				key_q <= request.key & key_mask(key_len);
				val_q <= request.value;
				wide_q <= eff_bytes(key_len) == 4'd8;
				x_q <= {60'b0, eff_bytes(key_len)};
				idx_q <= '0;
			end
			F_LOAD: opa_q <= (op_q == OP_ROT) ? {x_q[36:0], x_q[63:37]} : (y ^ (y >> 30));
			F_MUL: begin
				if (mph_q == 2'd0) acc_q <= prod;
				else acc_q <= acc_q + {prod[31:0], 32'b0};
			end
			F_POST: begin
				if (op_q == OP_ROT) x_q <= acc_q + WIDE_ADD;
				else if (!half_q) opa_q <= acc_q ^ (acc_q >> 27);
				else begin
					case (op_q)
						OP_N: begin hn_q <= mixed; x_q <= key_q; end
						OP_K: x_q <= hn_q ^ mixed;
						default: idx_q <= mixed[IDX_W-1:0];
					endcase
				end
			end
			default: ;
		endcase
	end

endmodule

// ----- design/hgagg_back.sv -----
// Back end: slot table, linear probe, aggregate update, readout scan and clearing pass.
module hgagg_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [10:0]        max_groups,
	input  logic               empty,
	input  hgagg_pkg::work_t   head,
	output logic               pop,
	output logic               init_busy,
	output logic               done,
	output hgagg_pkg::result_t result
);
	import hgagg_pkg::*;

	localparam logic [2:0] B_INIT = 3'd0;
	localparam logic [2:0] B_IDLE = 3'd1;
	localparam logic [2:0] B_PCHK = 3'd2;
	localparam logic [2:0] B_UPD1 = 3'd3;
	localparam logic [2:0] B_UPD2 = 3'd4;
	localparam logic [2:0] B_SCAN = 3'd5;
	localparam logic [2:0] B_CLR = 3'd6;

	entry_t mem [SLOTS];
	entry_t rdata_q, ent_q, hit_q, wdata, new_ent;
	logic we;
	logic [IDX_W-1:0] waddr, raddr;

	logic [2:0] bst_q;
	work_t it_q;
	logic [IDX_W-1:0] probe_q, steps_q, pos_q, clr_q;
	logic [POS_W-1:0] total_q, scan_q;
	logic found_q, carry_q, done_q;
	logic [63:0] lo_q, min_q, max_q, upd_hi;
	logic [47:0] cnt_q;
	logic [64:0] sum65;
	logic match;
	logic fin;
	result_t res_q;

	function automatic result_t group_res(input logic [2:0] st, input entry_t e,
		input logic last);
		result_t r;
		r.status = st;
		r.group_key = e.key;
		r.row_count = e.count;
		r.sum_low = e.sum_lo;
		r.sum_high = e.sum_hi;
		r.min_value = e.min;
		r.max_value = e.max;
		r.last_group = last;
		return r;
	endfunction

	function automatic result_t plain_res(input logic [2:0] st, input logic [63:0] k);
		result_t r;
		r = '0;
		r.status = st;
		r.group_key = k;
		return r;
	endfunction

	assign pop = (bst_q == B_IDLE) && !empty;
	assign init_busy = bst_q == B_INIT;
	assign done = done_q;
	assign result = res_q;

	assign match = (rdata_q.key & it_q.mask) == it_q.key;
	assign sum65 = {1'b0, ent_q.sum_lo} + {1'b0, it_q.value};
	assign upd_hi = ent_q.sum_hi + {64{it_q.value[63]}} + {63'b0, carry_q};
	assign new_ent = '{valid: 1'b1, key: it_q.key, count: 48'd1, sum_lo: it_q.value,
		sum_hi: {64{it_q.value[63]}}, min: it_q.value, max: it_q.value};

	always_comb begin
		we = 1'b0;
		waddr = probe_q;
		wdata = '0;
		raddr = pos_q + 1'b1;
		fin = 1'b0;
		case (bst_q)
			B_INIT, B_CLR: begin
				we = 1'b1;
				waddr = clr_q;
				fin = (bst_q == B_CLR) && (&clr_q);
			end
			B_IDLE: begin
				raddr = (head.cmd == CMD_UPDATE) ? head.idx : scan_q[IDX_W-1:0];
				case (head.cmd)
					CMD_READ: fin = !empty && scan_q[IDX_W];
					CMD_UPDATE, CMD_CLEAR: fin = 1'b0;
					default: fin = !empty;
				endcase
			end
			B_PCHK: begin
				raddr = probe_q + 1'b1;
				fin = !rdata_q.valid || (!match && (&steps_q));
				if (!rdata_q.valid && total_q < max_groups) begin
					we = 1'b1;
					wdata = new_ent;
				end
			end
			B_UPD2: begin
				we = 1'b1;
				fin = 1'b1;
				wdata = '{valid: 1'b1, key: ent_q.key, count: cnt_q, sum_lo: lo_q,
					sum_hi: upd_hi, min: min_q, max: max_q};
			end
			B_SCAN: fin = found_q ? (rdata_q.valid || (&pos_q)) : (&pos_q);
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bst_q <= B_INIT;
			it_q <= '0;
			probe_q <= '0;
			steps_q <= '0;
			pos_q <= '0;
			clr_q <= '0;
			total_q <= '0;
			scan_q <= '0;
			found_q <= 1'b0;
			carry_q <= 1'b0;
			done_q <= 1'b0;
			lo_q <= '0;
			min_q <= '0;
			max_q <= '0;
			cnt_q <= '0;
			ent_q <= '0;
			hit_q <= '0;
			res_q <= '0;
		end else begin
			done_q <= fin;
			case (bst_q)
				B_INIT: begin
					clr_q <= clr_q + 1'b1;
					if (&clr_q) bst_q <= B_IDLE;
				end
				B_IDLE: if (!empty) begin
					it_q <= head;
					case (head.cmd)
						CMD_UPDATE: begin
							probe_q <= head.idx;
							steps_q <= '0;
							bst_q <= B_PCHK;
						end
						CMD_READ: begin
							if (scan_q[IDX_W]) begin
								scan_q <= '0;
								res_q <= plain_res(ST_NO_MORE, '0);
							end else begin
								pos_q <= scan_q[IDX_W-1:0];
								found_q <= 1'b0;
								bst_q <= B_SCAN;
							end
						end
						CMD_CLEAR: begin
							clr_q <= '0;
							bst_q <= B_CLR;
						end
						default: res_q <= plain_res(ST_NO_MORE, '0);
					endcase
				end
				B_PCHK: begin
					if (!rdata_q.valid) begin
						bst_q <= B_IDLE;
						if (total_q < max_groups) begin
							total_q <= total_q + 1'b1;
							res_q <= group_res(ST_NEW, new_ent, 1'b0);
						end else begin
							res_q <= plain_res(ST_DROPPED, it_q.key);
						end
					end else if (match) begin
						ent_q <= rdata_q;
						bst_q <= B_UPD1;
					end else if (&steps_q) begin
						res_q <= plain_res(ST_DROPPED, it_q.key);
						bst_q <= B_IDLE;
					end else begin
						probe_q <= probe_q + 1'b1;
						steps_q <= steps_q + 1'b1;
					end
				end
				B_UPD1: begin
					lo_q <= sum65[63:0];
					carry_q <= sum65[64];
					cnt_q <= (&ent_q.count) ? ent_q.count : ent_q.count + 48'd1;
					min_q <= (it_q.value < $signed(ent_q.min)) ? it_q.value : ent_q.min;
					max_q <= ($signed(ent_q.max) < it_q.value) ? it_q.value : ent_q.max;
					bst_q <= B_UPD2;
				end
				B_UPD2: begin
					res_q <= group_res(ST_UPDATED, wdata, 1'b0);
					bst_q <= B_IDLE;
				end
				B_SCAN: begin
					pos_q <= pos_q + 1'b1;
					if (!found_q) begin
						if (rdata_q.valid) begin
							hit_q <= rdata_q;
							found_q <= 1'b1;
							scan_q <= {1'b0, pos_q} + 1'b1;
							if (&pos_q) begin
								res_q <= group_res(ST_GROUP, rdata_q, 1'b1);
								bst_q <= B_IDLE;
							end
						end else if (&pos_q) begin
							scan_q <= '0;
							res_q <= plain_res(ST_NO_MORE, '0);
							bst_q <= B_IDLE;
						end
					end else if (rdata_q.valid || (&pos_q)) begin
						res_q <= group_res(ST_GROUP, hit_q, !rdata_q.valid);
						bst_q <= B_IDLE;
					end
				end
				B_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (&clr_q) begin
						total_q <= '0;
						scan_q <= '0;
						res_q <= plain_res(ST_CLEARED, '0);
						bst_q <= B_IDLE;
					end
				end
				default: bst_q <= B_IDLE;
			endcase
		end
	end

endmodule
